FILE: rtl/dpht_pkg.sv
// Package for the depth-preferred hash table: table geometry, request codes,
// entry layout and the per-request update record. No dependencies.
package dpht_pkg;

  localparam int TABLE_SLOTS_LOG2 = 10;
  localparam int TABLE_SLOTS      = 1 << TABLE_SLOTS_LOG2;
  localparam int ENTRY_COUNT      = 2 * TABLE_SLOTS;
  localparam int ADDR_W           = TABLE_SLOTS_LOG2 + 1;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 120;

  typedef enum logic [1:0] {
    REQ_PROBE     = 2'd0,
    REQ_KEEP_BEST = 2'd1,
    REQ_FORCED    = 2'd2
  } req_t;

  typedef struct packed {
    logic [63:0]        key;
    logic signed [15:0] depth;
    logic signed [15:0] value;
    logic [15:0]        move;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               we;
    logic               coll_inc;
    logic               repl_inc;
    logic               hit;
    logic signed [15:0] value;
  } update_t;

endpackage

FILE: rtl/dpht_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
module dpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/dpht_update.sv
// Decision logic for one request against the addressed entry: hit, write
// enable and counter increments. Depends on dpht_pkg.
module dpht_update
  import dpht_pkg::*;
(
  input  req_t               req,
  input  logic [63:0]        key,
  input  logic signed [15:0] depth,
  input  entry_t             entry,
  output update_t            upd
);

  logic key_match;
  logic empty;
  logic coll;
  logic deeper;

  assign key_match = (entry.key == key);
  assign empty     = (entry.key == 64'd0);
  assign coll      = !key_match && !empty;
  assign deeper    = (depth > entry.depth);

  always_comb begin
    upd = '0;
    unique case (req)
      REQ_PROBE: begin
        upd.hit   = key_match;
        upd.value = entry.value;
      end
      REQ_KEEP_BEST: begin
        upd.we       = !coll || deeper;
        upd.coll_inc = coll;
        upd.repl_inc = coll && deeper;
      end
      REQ_FORCED: begin
        upd.we = 1'b1;
      end
      default: begin
        upd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/depth_preferred_hash_table_core.sv
// Depth-preferred hash table core: slot RAM, clearing pass, request stage,
// counters and output register. Depends on dpht_pkg, dpht_ram, dpht_update.
//
// Use: requests arrive on s_axis (tuser = request kind, tdata = key, side,
// depth, value, move). Each request gives exactly one result on m_axis
// (hit, stored value, write/collision/replacement counts after the request).
// The slot entry is {key[TABLE_SLOTS_LOG2-1:0], side}.
// Path: a request and its RAM read are registered in the request stage,
// then its result in the output register. Throughput: one request per
// cycle unless clearing or stalled, set by the single RAM read port; the
// write-back is forwarded to a back-to-back request to the same entry.
// Reset: the counters clear and a clearing pass writes zero to all
// ENTRY_COUNT entries, during which s_axis_tready is low.
// Stall: while m_axis_tready is low the result holds; one more request is
// taken and held in the request stage, then s_axis_tready drops.
module depth_preferred_hash_table_core
  import dpht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // hash_key[63:0], side[64], search_depth[80:65], game_value[96:81],
  // move_index[112:97], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // hit[0], stored_value[16:1], stored_count[48:17], collision_count[80:49],
  // replaced_count[112:81], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic               clearing;
  logic [ADDR_W-1:0]  clr_addr;

  logic               s1_valid;
  req_t               s1_req;
  logic [ADDR_W-1:0]  s1_addr;
  entry_t             s1_item;
  logic               s1_fwd;
  entry_t             fwd_entry;
  entry_t             rd_entry;
  entry_t             cur_entry;
  update_t            upd;

  logic               in_accept;
  logic               s1_advance;
  logic [ADDR_W-1:0]  in_addr;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  entry_t             wr_data;

  logic [31:0]        cnt_stored;
  logic [31:0]        cnt_coll;
  logic [31:0]        cnt_repl;
  logic [31:0]        cnt_stored_next;
  logic [31:0]        cnt_coll_next;
  logic [31:0]        cnt_repl_next;

  logic               out_valid;
  logic               out_hit;
  logic signed [15:0] out_value;
  logic [31:0]        out_stored;
  logic [31:0]        out_coll;
  logic [31:0]        out_repl;

  assign s1_advance    = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !clearing && (!s1_valid || s1_advance);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_addr       = {s_axis_tdata[TABLE_SLOTS_LOG2-1:0], s_axis_tdata[64]};

  assign cur_entry = s1_fwd ? fwd_entry : rd_entry;

  dpht_update u_update (
    .req   (s1_req),
    .key   (s1_item.key),
    .depth (s1_item.depth),
    .entry (cur_entry),
    .upd   (upd)
  );

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = s1_advance && upd.we;
      wr_addr = s1_addr;
      wr_data = s1_item;
    end
  end

  dpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (rd_entry)
  );

  assign cnt_stored_next = cnt_stored + {31'd0, upd.we};
  assign cnt_coll_next   = cnt_coll + {31'd0, upd.coll_inc};
  assign cnt_repl_next   = cnt_repl + {31'd0, upd.repl_inc};

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(ENTRY_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req        <= req_t'(s_axis_tuser);
      s1_addr       <= in_addr;
      s1_item.key   <= s_axis_tdata[63:0];
      s1_item.depth <= s_axis_tdata[80:65];
      s1_item.value <= s_axis_tdata[96:81];
      s1_item.move  <= s_axis_tdata[112:97];
      s1_fwd        <= s1_advance && upd.we && (in_addr == s1_addr);
    end
    if (wr_en) begin
      fwd_entry <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_stored <= '0;
      cnt_coll   <= '0;
      cnt_repl   <= '0;
    end else if (s1_advance) begin
      cnt_stored <= cnt_stored_next;
      cnt_coll   <= cnt_coll_next;
      cnt_repl   <= cnt_repl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_hit    <= upd.hit;
      out_value  <= upd.value;
      out_stored <= cnt_stored_next;
      out_coll   <= cnt_coll_next;
      out_repl   <= cnt_repl_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_repl, out_coll, out_stored, out_value, out_hit};

endmodule

FILE: rtl/dpht_checker.sv
// Port-level checker for the hash table core, bound to the top level.
// Depends on dpht_pkg and depth_preferred_hash_table_core.
module dpht_checker
  import dpht_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // clearing pass blocks requests straight after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("request accepted during clearing pass");

  // an empty output register is only refilled by an accepted transaction that has passed the request stage
  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without matching request");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind depth_preferred_hash_table_core dpht_checker u_checker (.*);

FILE: tb/tb_depth_preferred_hash_table_core.sv
// Testbench for depth_preferred_hash_table_core: streams probe and store requests,
// predicts each result and compares every field. Depends on dpht_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_depth_preferred_hash_table_core;
  import dpht_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 1950;
  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         POOL_SIZE    = 24;
  localparam int         HOT_SLOTS    = 6;

  typedef struct packed {
    logic [1:0]         kind;
    logic [63:0]        key;
    logic               side;
    logic signed [15:0] depth;
    logic signed [15:0] value;
    logic [15:0]        move;
  } request_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] value;
    logic [31:0]        writes;
    logic [31:0]        collisions;
    logic [31:0]        replacements;
  } table_result_t;

  // Keeps its own copy of the slot table and counters; one result per request.
  class table_scoreboard;
    logic [63:0]        key_tab[ENTRY_COUNT];
    logic signed [15:0] depth_tab[ENTRY_COUNT];
    logic signed [15:0] value_tab[ENTRY_COUNT];
    logic [15:0]        move_tab[ENTRY_COUNT];
    logic [31:0]        writes_total;
    logic [31:0]        collisions_total;
    logic [31:0]        replacements_total;
    table_result_t      expected_results[$];
    int                 failures;

    function new();
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        key_tab[i]   = '0;
        depth_tab[i] = '0;
        value_tab[i] = '0;
        move_tab[i]  = '0;
      end
      writes_total       = '0;
      collisions_total   = '0;
      replacements_total = '0;
      failures           = 0;
    endfunction

    function void write_entry(int idx, request_t r);
      writes_total   = writes_total + 1;
      key_tab[idx]   = r.key;
      depth_tab[idx] = r.depth;
      value_tab[idx] = r.value;
      move_tab[idx]  = r.move;
    endfunction

    function void note_request(request_t r);
      table_result_t res;
      int            idx;
      res = '0;
      idx = int'({r.key[TABLE_SLOTS_LOG2-1:0], r.side});
      case (r.kind)
        REQ_PROBE: begin
          res.hit   = (key_tab[idx] == r.key);
          res.value = value_tab[idx];
        end
        REQ_KEEP_BEST: begin
          if (key_tab[idx] != r.key && key_tab[idx] != 64'd0) begin
            collisions_total = collisions_total + 1;
            if ($signed(r.depth) > $signed(depth_tab[idx])) begin
              replacements_total = replacements_total + 1;
              write_entry(idx, r);
            end
          end else begin
            write_entry(idx, r);
          end
        end
        REQ_FORCED: write_entry(idx, r);
        default: ;
      endcase
      res.writes       = writes_total;
      res.collisions   = collisions_total;
      res.replacements = replacements_total;
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      table_result_t want;
      if (expected_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        failures++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("hit", longint'(want.hit), longint'(d[0]));
      compare_field("stored_value", longint'(want.value), longint'($signed(d[16:1])));
      compare_field("stored_count", longint'(want.writes), longint'(d[48:17]));
      compare_field("collision_count", longint'(want.collisions), longint'(d[80:49]));
      compare_field("replaced_count", longint'(want.replacements), longint'(d[112:81]));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  table_scoreboard sb = new();
  bit              calm;
  int unsigned     cycle_count = 0;
  logic [63:0]     key_pool[POOL_SIZE];
  logic [63:0]     last_key;

  depth_preferred_hash_table_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      sb.note_request({s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[64],
                       s_axis_tdata[80:65], s_axis_tdata[96:81], s_axis_tdata[112:97]});
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
  end

  // mostly short gaps, the odd long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int unsigned stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 15) stall_left = pick_gap();
      end
    end
  end

  task automatic send_request(logic [1:0] kind, logic [63:0] key, logic side,
                              logic [15:0] depth, logic [15:0] value, logic [15:0] move);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'd0, move, value, depth, side, key};
    last_key = key;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic run_directed();
    logic [63:0] k1;
    logic [63:0] k2;
    k1 = 64'h0123_4567_89AB_C155;
    k2 = 64'hFEDC_BA98_7654_3155;
    send_request(REQ_PROBE, 64'd0, 1'b0, 16'd0, 16'd0, 16'd0);
    send_request(REQ_PROBE, '1, 1'b1, 16'd0, 16'd0, 16'd0);
    send_request(REQ_KEEP_BEST, k1, 1'b0, 16'd5, 16'h1234, 16'h00AA);
    send_request(REQ_PROBE, k1, 1'b0, 16'd0, 16'd0, 16'd0);
    send_request(REQ_PROBE, k1, 1'b1, 16'd0, 16'd0, 16'd0);
    send_request(REQ_KEEP_BEST, k1, 1'b0, -16'sd3, -16'sd77, 16'h5555);
    // same slot, other key: equal and shallower depths lose, deeper wins
    send_request(REQ_KEEP_BEST, k2, 1'b0, -16'sd3, 16'd9, 16'd1);
    send_request(REQ_KEEP_BEST, k2, 1'b0, -16'sd4, 16'd9, 16'd1);
    send_request(REQ_KEEP_BEST, k2, 1'b0, 16'd100, 16'd321, 16'd2);
    send_request(REQ_PROBE, k1, 1'b0, 16'd0, 16'd0, 16'd0);
    send_request(REQ_FORCED, k1, 1'b0, 16'h8000, 16'h8000, 16'h0000);
    send_request(REQ_KEEP_BEST, k2, 1'b0, 16'h8000, 16'd1, 16'd1);
    send_request(REQ_KEEP_BEST, k2, 1'b0, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_request(REQ_PROBE, k2, 1'b0, 16'd0, 16'd0, 16'd0);
    send_request(REQ_UNUSED, k2, 1'b1, '1, '1, '1);
    send_request(REQ_FORCED, 64'd0, 1'b1, 16'h7FFF, -16'sd5, 16'h0F0F);
    send_request(REQ_PROBE, 64'd0, 1'b1, 16'd0, 16'd0, 16'd0);
    send_request(REQ_KEEP_BEST, 64'h0000_0000_0001_0000, 1'b1, 16'd1, 16'd2, 16'd3);
    send_request(REQ_PROBE, '1, 1'b1, 16'd0, 16'd0, 16'd0);
    send_request(REQ_FORCED, '1, 1'b1, 16'd0, 16'h8000, 16'hFFFF);
    send_request(REQ_PROBE, '1, 1'b1, 16'd0, 16'd0, 16'd0);
    send_request(REQ_KEEP_BEST, 64'h8000_0000_0000_03FF, 1'b1, 16'd0, 16'd4, 16'd4);
    send_request(REQ_KEEP_BEST, 64'h8000_0000_0000_03FF, 1'b1, 16'd1, 16'd4, 16'd4);
    send_request(REQ_PROBE, 64'h8000_0000_0000_03FF, 1'b1, 16'd0, 16'd0, 16'd0);
  endtask

  function automatic logic [15:0] pick_depth();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($signed($urandom_range(0, 30)) - 15);
    if (r < 80) return 16'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return 16'h0000;
    endcase
  endfunction

  // keys crowd into a few slots so hits, collisions and replacements are common
  task automatic build_key_pool();
    logic [TABLE_SLOTS_LOG2-1:0] hot[HOT_SLOTS];
    hot[0] = '0;
    hot[1] = '1;
    for (int i = 2; i < HOT_SLOTS; i++) hot[i] = TABLE_SLOTS_LOG2'($urandom);
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = {$urandom, $urandom};
      key_pool[i][TABLE_SLOTS_LOG2-1:0] = hot[$urandom_range(0, HOT_SLOTS - 1)];
    end
  endtask

  task automatic random_request();
    logic [1:0]  kind;
    logic [63:0] key;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) kind = REQ_PROBE;
    else if (r < 75) kind = REQ_KEEP_BEST;
    else if (r < 95) kind = REQ_FORCED;
    else kind = REQ_UNUSED;
    r = $urandom_range(0, 99);
    if (r < 25) key = last_key;
    else if (r < 80) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (r < 85) key = 64'd0;
    else key = {$urandom, $urandom};
    send_request(kind, key, 1'($urandom), pick_depth(), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    calm          = 1'b0;
    last_key      = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    build_key_pool();
    run_directed();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      random_request();
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    calm = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
